>>> hdl/sca_pkg.sv
// Shared types and constants for the size-class slab allocator.
// Holds the job record that travels from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sca_pkg;

   localparam int DEF_NUM_PAGES = 256;
   localparam int DEF_PAGE_BYTES = 4096;
   localparam int DEF_NUM_CLASSES = 10;
   localparam int DEF_MAX_SLOTS = 1024;
   localparam int DEF_PAGE_HEADER_BYTES = 16;
   localparam int DEF_SLOT_HEADER_BYTES = 4;

   localparam int SIZE_W = 16;
   localparam int PAGE_W = 8;
   localparam int SLOT_W = 10;
   localparam int CLS_W = 4;
   localparam int ADDR_W = 20;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ZERO   = 2'd1,
      ST_BIG    = 2'd2,
      ST_NOPAGE = 2'd3
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_REPLY = 2'd2
   } op_type;

   typedef struct packed {
      op_type             op;
      status_type         status;
      logic [CLS_W-1:0]   cls;
      logic [PAGE_W-1:0]  free_page;
      logic [SLOT_W-1:0]  free_slot;
   } job_type;

endpackage
`default_nettype wire

>>> hdl/sca_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> hdl/sca_front.sv
// Front end: decodes a request and sorts an allocate into its size class.
// Depends on sca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sca_front #(
   parameter int PAGE_BYTES = sca_pkg::DEF_PAGE_BYTES,
   parameter int NUM_CLASSES = sca_pkg::DEF_NUM_CLASSES,
   parameter int PAGE_HEADER_BYTES = sca_pkg::DEF_PAGE_HEADER_BYTES,
   parameter int SLOT_HEADER_BYTES = sca_pkg::DEF_SLOT_HEADER_BYTES
) (
   input  wire logic                          req_kind,
   input  wire logic [sca_pkg::SIZE_W-1:0]    request_size,
   input  wire logic [sca_pkg::PAGE_W-1:0]    free_page,
   input  wire logic [sca_pkg::SLOT_W-1:0]    free_slot,
   output sca_pkg::job_type                   job
);
   import sca_pkg::*;

   localparam int MAX_BLOCK = 2 << (NUM_CLASSES - 1);
   localparam int ROOM = PAGE_BYTES - PAGE_HEADER_BYTES;

   logic [CLS_W-1:0] cls;

   always_comb begin
      cls = '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         if ((32'd2 << i) < 32'(request_size)) begin
            cls = cls + CLS_W'(1);
         end
      end
   end

   always_comb begin
      job.op = OP_REPLY;
      job.status = ST_OK;
      job.cls = '0;
      job.free_page = free_page;
      job.free_slot = free_slot;
      if (req_kind == REQ_FREE) begin
         job.op = OP_FREE;
      end else if (request_size == '0) begin
         job.status = ST_ZERO;
      end else if (32'(request_size) > 32'(MAX_BLOCK)) begin
         job.status = ST_BIG;
      end else if ((32'd2 << cls) + 32'(SLOT_HEADER_BYTES) > 32'(ROOM)) begin
         job.status = ST_BIG;
      end else begin
         job.op = OP_ALLOC;
         job.cls = cls;
      end
   end

endmodule
`default_nettype wire

>>> hdl/sca_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on sca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sca_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire sca_pkg::job_type  push_job,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output sca_pkg::job_type       pop_job,
   output logic                   full
);
   import sca_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wp_ff, wp_in;
   logic [PTR_W-1:0]     rp_ff, rp_in;
   logic [PTR_W:0]       cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign full = (cnt_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign push_ready = !full;
   assign pop_valid = (cnt_ff != '0);
   assign pop_job = mem_ff[rp_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wp_in = do_push ? wp_ff + PTR_W'(1) : wp_ff;
      rp_in = do_pop ? rp_ff + PTR_W'(1) : rp_ff;
      cnt_in = cnt_ff + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wp_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

>>> hdl/sca_back.sv
// Back end: walks the class queues, page records and slot free lists.
// Depends on sca_pkg and sca_ram.
`timescale 1ns / 1ps
`default_nettype none
module sca_back #(
   parameter int NUM_PAGES = sca_pkg::DEF_NUM_PAGES,
   parameter int PAGE_BYTES = sca_pkg::DEF_PAGE_BYTES,
   parameter int NUM_CLASSES = sca_pkg::DEF_NUM_CLASSES,
   parameter int MAX_SLOTS = sca_pkg::DEF_MAX_SLOTS,
   parameter int PAGE_HEADER_BYTES = sca_pkg::DEF_PAGE_HEADER_BYTES,
   parameter int SLOT_HEADER_BYTES = sca_pkg::DEF_SLOT_HEADER_BYTES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              job_valid,
   input  wire sca_pkg::job_type                  job,
   output logic                                   job_pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sca_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [1:0]                             rsp_tuser,
   output logic                                   clearing
);
   import sca_pkg::*;

   localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int HW = $clog2(NUM_PAGES + 1);
   localparam int SIW = $clog2(MAX_SLOTS);
   localparam int SW = $clog2(MAX_SLOTS + 1);
   localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int LAW = PW + SIW;
   localparam int STW = $clog2(SLOT_HEADER_BYTES + (2 << (NUM_CLASSES - 1)) + 1);
   localparam logic [SW-1:0] LIST_END = SW'(MAX_SLOTS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_A_RD, S_A_SLOT, S_A_POP, S_F_CHK, S_F_ENQ, S_DONE
   } state_type;

   logic [SW-1:0]  slot_cnt [NUM_CLASSES];
   logic [STW-1:0] stride [NUM_CLASSES];

   for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_class
      localparam int STRIDE_I = SLOT_HEADER_BYTES + (2 << i);
      localparam int RAW_I = (PAGE_BYTES - PAGE_HEADER_BYTES) / STRIDE_I;
      localparam int CNT_I = (RAW_I > MAX_SLOTS) ? MAX_SLOTS : RAW_I;
      assign slot_cnt[i] = SW'(CNT_I);
      assign stride[i] = STW'(STRIDE_I);
   end

   state_type           state_ff, state_in;
   logic [LAW-1:0]      clr_ff, clr_in;
   logic [HW-1:0]       handed_ff, handed_in;
   logic                qvalid_ff [NUM_CLASSES];
   logic                qvalid_in [NUM_CLASSES];
   logic [PW-1:0]       qhead_ff [NUM_CLASSES];
   logic [PW-1:0]       qhead_in [NUM_CLASSES];
   logic [PW-1:0]       qtail_ff [NUM_CLASSES];
   logic [PW-1:0]       qtail_in [NUM_CLASSES];
   job_type             job_ff, job_in;
   logic [PW-1:0]       page_ff, page_in;
   logic [SIW-1:0]      slot_ff, slot_in;
   logic                nvalid_ff, nvalid_in;
   logic [PW-1:0]       nnext_ff, nnext_in;
   status_type          res_status_ff, res_status_in;
   logic [CLS_W-1:0]    res_cls_ff, res_cls_in;
   logic [PAGE_W-1:0]   res_page_ff, res_page_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic                  page_we;
   logic [PW-1:0]         page_waddr, page_raddr;
   logic [CLS_W+SW-1:0]   page_wdata, page_rd;
   logic                  next_we;
   logic [PW-1:0]         next_waddr, next_raddr;
   logic [PW:0]           next_wdata, next_rd;
   logic                  link_we;
   logic [LAW-1:0]        link_waddr, link_raddr;
   logic [SW:0]           link_wdata, link_rd;

   sca_ram #(.WIDTH(CLS_W + SW), .DEPTH(NUM_PAGES)) u_page_ram (
      .clock(clock), .wr_en(page_we), .wr_addr(page_waddr), .wr_data(page_wdata),
      .rd_addr(page_raddr), .rd_data(page_rd)
   );

   sca_ram #(.WIDTH(PW + 1), .DEPTH(NUM_PAGES)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_waddr), .wr_data(next_wdata),
      .rd_addr(next_raddr), .rd_data(next_rd)
   );

   sca_ram #(.WIDTH(SW + 1), .DEPTH(2 ** LAW)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
      .rd_addr(link_raddr), .rd_data(link_rd)
   );

   logic [CW-1:0]    cidx, pidx;
   logic [CLS_W-1:0] pg_cls;
   logic [SW-1:0]    pg_head;
   logic [SW-1:0]    succ, nxt;
   logic [31:0]      addr_sum;

   assign cidx = CW'(job_ff.cls);
   assign pg_cls = page_rd[CLS_W+SW-1:SW];
   assign pg_head = page_rd[SW-1:0];
   assign pidx = CW'(pg_cls);

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      handed_in = handed_ff;
      qvalid_in = qvalid_ff;
      qhead_in = qhead_ff;
      qtail_in = qtail_ff;
      job_in = job_ff;
      page_in = page_ff;
      slot_in = slot_ff;
      nvalid_in = nvalid_ff;
      nnext_in = nnext_ff;
      res_status_in = res_status_ff;
      res_cls_in = res_cls_ff;
      res_page_in = res_page_ff;
      res_slot_in = res_slot_ff;
      res_addr_in = res_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      job_pop = 1'b0;
      page_we = 1'b0;
      page_waddr = page_ff;
      page_wdata = '0;
      page_raddr = page_ff;
      next_we = 1'b0;
      next_waddr = page_ff;
      next_wdata = '0;
      next_raddr = page_ff;
      link_we = 1'b0;
      link_waddr = clr_ff;
      link_wdata = '0;
      link_raddr = '0;
      succ = ((32'(slot_ff) + 32'd1) == 32'(slot_cnt[cidx])) ? LIST_END
                                                             : SW'(32'(slot_ff) + 32'd1);
      nxt = link_rd[SW] ? link_rd[SW-1:0] : succ;
      addr_sum = 32'(page_ff) * 32'(PAGE_BYTES) + 32'(PAGE_HEADER_BYTES)
               + 32'(slot_ff) * 32'(stride[cidx]) + 32'(SLOT_HEADER_BYTES);

      case (state_ff)
         S_CLEAR: begin
            link_we = 1'b1;
            clr_in = clr_ff + LAW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               job_in = job;
               res_status_in = job.status;
               res_cls_in = job.cls;
               res_page_in = '0;
               res_slot_in = '0;
               res_addr_in = '0;
               state_in = S_DONE;
               case (job.op)
                  OP_FREE: begin
                     if (32'(job.free_page) < 32'(handed_ff)) begin
                        page_raddr = PW'(job.free_page);
                        state_in = S_F_CHK;
                     end
                  end
                  OP_ALLOC: begin
                     if (qvalid_ff[CW'(job.cls)]) begin
                        page_in = qhead_ff[CW'(job.cls)];
                        page_raddr = qhead_ff[CW'(job.cls)];
                        next_raddr = qhead_ff[CW'(job.cls)];
                        state_in = S_A_SLOT;
                     end else if (32'(handed_ff) == 32'(NUM_PAGES)) begin
                        res_status_in = ST_NOPAGE;
                     end else begin
                        page_we = 1'b1;
                        page_waddr = PW'(handed_ff);
                        page_wdata = {job.cls, SW'(0)};
                        next_we = 1'b1;
                        next_waddr = PW'(handed_ff);
                        qvalid_in[CW'(job.cls)] = 1'b1;
                        qhead_in[CW'(job.cls)] = PW'(handed_ff);
                        qtail_in[CW'(job.cls)] = PW'(handed_ff);
                        handed_in = handed_ff + HW'(1);
                        page_in = PW'(handed_ff);
                        state_in = S_A_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_A_RD: begin
            state_in = S_A_SLOT;
         end
         S_A_SLOT: begin
            slot_in = (32'(pg_head) >= 32'(slot_cnt[cidx])) ? '0 : SIW'(pg_head);
            link_raddr = {page_ff, slot_in};
            nvalid_in = next_rd[PW];
            nnext_in = next_rd[PW-1:0];
            state_in = S_A_POP;
         end
         S_A_POP: begin
            page_we = 1'b1;
            page_wdata = {job_ff.cls, nxt};
            if (nxt == LIST_END) begin
               if (nvalid_ff) begin
                  qhead_in[cidx] = nnext_ff;
               end else begin
                  qvalid_in[cidx] = 1'b0;
                  qhead_in[cidx] = '0;
                  qtail_in[cidx] = '0;
               end
            end
            res_page_in = PAGE_W'(page_ff);
            res_slot_in = SLOT_W'(slot_ff);
            res_addr_in = addr_sum[ADDR_W-1:0];
            state_in = S_DONE;
         end
         S_F_CHK: begin
            state_in = S_DONE;
            if (32'(job_ff.free_slot) < 32'(slot_cnt[pidx])) begin
               link_we = 1'b1;
               link_waddr = {PW'(job_ff.free_page), SIW'(job_ff.free_slot)};
               link_wdata = {1'b1, pg_head};
               page_we = 1'b1;
               page_waddr = PW'(job_ff.free_page);
               page_wdata = {pg_cls, SW'(job_ff.free_slot)};
               if (pg_head == LIST_END) begin
                  if (qvalid_ff[pidx]) begin
                     next_we = 1'b1;
                     next_waddr = qtail_ff[pidx];
                     next_wdata = {1'b1, PW'(job_ff.free_page)};
                  end else begin
                     qhead_in[pidx] = PW'(job_ff.free_page);
                     qvalid_in[pidx] = 1'b1;
                  end
                  qtail_in[pidx] = PW'(job_ff.free_page);
                  state_in = S_F_ENQ;
               end
            end
         end
         S_F_ENQ: begin
            next_we = 1'b1;
            next_waddr = PW'(job_ff.free_page);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in = {(RSP_DATA_W - ADDR_W - SLOT_W - PAGE_W - CLS_W)'(0),
                              res_addr_ff, res_slot_ff, res_page_ff, res_cls_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         handed_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            qvalid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         handed_ff <= handed_in;
         rsp_valid_ff <= rsp_valid_in;
         qvalid_ff <= qvalid_in;
      end
      qhead_ff <= qhead_in;
      qtail_ff <= qtail_in;
      job_ff <= job_in;
      page_ff <= page_in;
      slot_ff <= slot_in;
      nvalid_ff <= nvalid_in;
      nnext_ff <= nnext_in;
      res_status_ff <= res_status_in;
      res_cls_ff <= res_cls_in;
      res_page_ff <= res_page_in;
      res_slot_ff <= res_slot_in;
      res_addr_ff <= res_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_status_ff;
   assign clearing = (state_ff == S_CLEAR);

endmodule
`default_nettype wire

>>> hdl/size_class_slab_allocator.sv
// Top level of the size-class slab allocator.
// Depends on sca_pkg, sca_front, sca_queue and sca_back (which uses sca_ram).
`timescale 1ns / 1ps
`default_nettype none
// Each transaction on the req side is an allocate or a free and yields exactly one
// transaction on the rsp side, in order. After reset the block clears the slot link
// memory, and req_tready stays low until that pass is done. A front end classifies
// requests into a two-entry queue; the back end then handles one transaction at a
// time in dependent reads of the page, queue-link and slot-link memories: a
// rejected request goes straight to its result, a free checks the slot and may
// enqueue its page, an allocate from a queued page reads and pops its free slot,
// and an allocate that takes a fresh page first sets that page up. A result that
// finds the previous one still unaccepted waits for rsp_tready.
module size_class_slab_allocator #(
   parameter int NUM_PAGES = sca_pkg::DEF_NUM_PAGES,
   parameter int PAGE_BYTES = sca_pkg::DEF_PAGE_BYTES,
   parameter int NUM_CLASSES = sca_pkg::DEF_NUM_CLASSES,
   parameter int MAX_SLOTS = sca_pkg::DEF_MAX_SLOTS,
   parameter int PAGE_HEADER_BYTES = sca_pkg::DEF_PAGE_HEADER_BYTES,
   parameter int SLOT_HEADER_BYTES = sca_pkg::DEF_SLOT_HEADER_BYTES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // request_size [15:0], free_page [23:16], free_slot [33:24], zeros above.
   input  wire logic [sca_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_type [0].
   input  wire logic [0:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // size_class [3:0], alloc_page [11:4], alloc_slot [21:12],
   // block_address [41:22], zeros above.
   output logic [sca_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // status [1:0].
   output logic [1:0]                           rsp_tuser
);
   import sca_pkg::*;

   job_type front_job, q_job;
   logic    q_ready, q_valid, q_pop, q_full, clearing;

   sca_front #(
      .PAGE_BYTES(PAGE_BYTES), .NUM_CLASSES(NUM_CLASSES),
      .PAGE_HEADER_BYTES(PAGE_HEADER_BYTES), .SLOT_HEADER_BYTES(SLOT_HEADER_BYTES)
   ) u_front (
      .req_kind(req_tuser[0]),
      .request_size(req_tdata[SIZE_W-1:0]),
      .free_page(req_tdata[SIZE_W+PAGE_W-1:SIZE_W]),
      .free_slot(req_tdata[SIZE_W+PAGE_W+SLOT_W-1:SIZE_W+PAGE_W]),
      .job(front_job)
   );

   sca_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(req_tvalid && !clearing), .push_ready(q_ready), .push_job(front_job),
      .pop_valid(q_valid), .pop_ready(q_pop), .pop_job(q_job), .full(q_full)
   );

   sca_back #(
      .NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES), .NUM_CLASSES(NUM_CLASSES),
      .MAX_SLOTS(MAX_SLOTS), .PAGE_HEADER_BYTES(PAGE_HEADER_BYTES),
      .SLOT_HEADER_BYTES(SLOT_HEADER_BYTES)
   ) u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_valid), .job(q_job), .job_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .clearing(clearing)
   );

   assign req_tready = q_ready && !clearing;

   a_err_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata[41:4] == '0))
      else $error("failed transaction carries page, slot or address");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_tready)
      else $error("request accepted while job queue is full");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!rsp_tvalid && !req_tready))
      else $error("traffic during link memory clearing");

endmodule
`default_nettype wire

>>> bench/size_class_slab_allocator_test.sv
// Self-checking bench for the size-class slab allocator: a built-in predictor
// mirrors class queues, page free lists and pool use; results are compared in order.
// Depends on sca_pkg and size_class_slab_allocator.
`timescale 1ns / 1ps
module size_class_slab_allocator_test;
   import sca_pkg::*;

   localparam int NPAGES = 256;
   localparam int NSLOTS = 1024;
   localparam int NCLASS = 10;
   localparam logic [10:0] LIST_END = 11'd1024;
   localparam int STALL_LIMIT = 1500000;

   typedef struct packed {
      status_type status;
      logic [3:0] cls;
      logic [7:0] page;
      logic [9:0] slot;
      logic [19:0] addr;
   } alloc_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   size_class_slab_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // Predictor state.
   bit cq_valid [NCLASS];
   logic [7:0] cq_head [NCLASS];
   logic [7:0] cq_tail [NCLASS];
   logic [10:0] pg_head [NPAGES];
   bit pg_next_valid [NPAGES];
   logic [7:0] pg_next [NPAGES];
   logic [3:0] pg_class [NPAGES];
   logic [10:0] links [int];
   int pages_used;

   alloc_result_type expected_q[$];
   // Live allocations, used to build meaningful frees.
   logic [17:0] live_blocks[$];
   int errors;
   int mismatches;
   int idle_cycles;
   bit hold_rsp;
   bit rsp_done;

   function automatic int slots_of(int c);
      int n;
      n = (4096 - 16) / (4 + (2 << c));
      return (n > NSLOTS) ? NSLOTS : n;
   endfunction

   function automatic void queue_page(int c, int p);
      if (cq_valid[c]) begin
         pg_next[cq_tail[c]] = 8'(p);
         pg_next_valid[cq_tail[c]] = 1;
      end else begin
         cq_head[c] = 8'(p);
         cq_valid[c] = 1;
      end
      cq_tail[c] = 8'(p);
      pg_next_valid[p] = 0;
   endfunction

   function automatic alloc_result_type predict_alloc(bit is_free, int size, int fp, int fs);
      alloc_result_type r;
      int c, n, p, s;
      r = '0;
      r.status = ST_OK;
      if (is_free) begin
         if (fp >= pages_used) return r;
         c = int'(pg_class[fp]);
         if (fs >= slots_of(c)) return r;
         if (pg_head[fp] == LIST_END) queue_page(c, fp);
         links[fp * NSLOTS + fs] = pg_head[fp];
         pg_head[fp] = 11'(fs);
         return r;
      end
      if (size == 0) begin
         r.status = ST_ZERO;
         return r;
      end
      if (size > 1024) begin
         r.status = ST_BIG;
         return r;
      end
      c = 0;
      while ((2 << c) < size) c++;
      n = slots_of(c);
      if (!cq_valid[c]) begin
         if (pages_used >= NPAGES) begin
            r.status = ST_NOPAGE;
            r.cls = 4'(c);
            return r;
         end
         p = pages_used;
         pages_used++;
         pg_class[p] = 4'(c);
         for (int i = 0; i < n; i++) begin
            links[p * NSLOTS + i] = (i + 1 < n) ? 11'(i + 1) : LIST_END;
         end
         pg_head[p] = '0;
         cq_head[c] = 8'(p);
         cq_tail[c] = 8'(p);
         cq_valid[c] = 1;
         pg_next_valid[p] = 0;
      end
      p = int'(cq_head[c]);
      s = int'(pg_head[p]);
      if (s >= n) s = 0;
      pg_head[p] = links[p * NSLOTS + s];
      if (pg_head[p] == LIST_END) begin
         if (pg_next_valid[p]) cq_head[c] = pg_next[p];
         else begin
            cq_valid[c] = 0;
            cq_head[c] = '0;
            cq_tail[c] = '0;
         end
      end
      r.cls = 4'(c);
      r.page = 8'(p);
      r.slot = 10'(s);
      r.addr = 20'(p * 4096 + 16 + s * (4 + (2 << c)) + 4);
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic send_request(bit is_free, int size, int fp, int fs);
      int gap;
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= is_free ? REQ_FREE : REQ_ALLOC;
      req_tdata <= {6'd0, fs[9:0], fp[7:0], size[15:0]};
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(predict_alloc(is_free, size, fp, fs));
   endtask

   task automatic send_alloc(int size);
      send_request(0, size, $urandom_range(0, 255), $urandom_range(0, 1023));
   endtask

   task automatic send_free_live();
      int k;
      logic [17:0] b;
      k = $urandom_range(0, live_blocks.size() - 1);
      b = live_blocks[k];
      live_blocks.delete(k);
      send_request(1, $urandom, b[17:10], b[9:0]);
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      alloc_result_type got, want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser);
            got.cls = rsp_tdata[3:0];
            got.page = rsp_tdata[11:4];
            got.slot = rsp_tdata[21:12];
            got.addr = rsp_tdata[41:22];
            if (expected_q.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected transaction %h", got);
            end else begin
               want = expected_q.pop_front();
               if (got != want || rsp_tdata[47:42] != 0) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display({"mismatch: expected st=%0d c=%0d p=%0d s=%0d a=%h,",
                               " got st=%0d c=%0d p=%0d s=%0d a=%h"},
                        want.status, want.cls, want.page, want.slot, want.addr,
                        got.status, got.cls, got.page, got.slot, got.addr);
               end else if (want.status == ST_OK && want.addr != 0 && $urandom_range(0, 2) != 0)
                  live_blocks.push_back({want.page, want.slot});
            end
         end
      end
   end

   // Receiver backpressure: random per-transaction stall, or a long hold.
   initial begin
      int w;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (w != 0) begin
            rsp_tready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready) && !hold_rsp);
      end
   end

   task automatic test_rejects();
      send_alloc(0);
      send_alloc(1025);
      send_alloc(16'hFFFF);
      send_alloc(16'h8000);
      send_request(1, 0, 200, 5);
   endtask

   task automatic test_classes();
      for (int c = 0; c < NCLASS; c++) send_alloc(2 << c);
      send_alloc(1);
      send_alloc(3);
      send_alloc(1024);
      send_request(1, 0, 0, 1023);
      send_request(1, 0, 9, 3);
      send_request(1, 0, 9, 1);
      send_alloc(1000);
      send_alloc(600);
      send_alloc(700);
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_rsp = 1;
      for (int i = 0; i < 20; i++) send_alloc($urandom_range(1, 64));
      wait_drained();
   endtask

   task automatic test_random(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40 && live_blocks.size() > 0) send_free_live();
         else if (pick < 85) send_alloc($urandom_range(1, 1024) >> $urandom_range(0, 9));
         else if (pick < 90) send_alloc($urandom_range(0, 65535));
         else send_request(1, $urandom, $urandom_range(0, 255), $urandom_range(0, 1023));
      end
      wait_drained();
   endtask

   initial begin
      errors = 0;
      mismatches = 0;
      hold_rsp = 0;
      pages_used = 0;
      for (int c = 0; c < NCLASS; c++) begin
         cq_valid[c] = 0;
         cq_head[c] = 0;
         cq_tail[c] = 0;
      end
      reset <= 1;
      req_tvalid <= 0;
      req_tdata <= '0;
      req_tuser <= '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      test_rejects();
      test_classes();
      test_backpressure();
      test_random(510);
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

>>> size_class_slab_allocator.f
hdl/sca_pkg.sv
hdl/sca_ram.sv
hdl/sca_front.sv
hdl/sca_queue.sv
hdl/sca_back.sv
hdl/size_class_slab_allocator.sv
bench/size_class_slab_allocator_test.sv
